// File: src/tpjp_pkg.sv
// Package for the three-phase joint profile unit: widths, phase codes and the
// structs that travel down the pipeline. No dependencies.
package tpjp_pkg;

	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned ANG_W      = 32;
	localparam int unsigned PT_W       = 15;
	localparam int unsigned ET_W       = 16;
	localparam int unsigned PH_W       = 2;
	// The move length 4*P^2 and the running remainder of the divider.
	localparam int unsigned D_W        = 2 * PT_W + 2;
	// Quotient bits: the rounded fraction runs from 0 up to 2^FRAC_BITS inclusive.
	localparam int unsigned Q_W        = FRAC_BITS + 1;
	localparam int unsigned N_W        = D_W + Q_W;
	localparam int unsigned PROD_W     = ANG_W + Q_W + 2;
	localparam int unsigned FIFO_DEPTH = 32;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = FIFO_AW + 1;

	localparam logic [PT_W-1:0] PT_RESET = PT_W'(2000);

	localparam logic [PH_W-1:0] PH_ACCEL  = 2'd0;
	localparam logic [PH_W-1:0] PH_STEADY = 2'd1;
	localparam logic [PH_W-1:0] PH_BRAKE  = 2'd2;

	typedef struct packed {
		logic signed [ANG_W-1:0] start;
		logic signed [ANG_W:0]   diff;
		logic [PH_W-1:0]         phase;
		logic                    done;
	} tpjp_side_t;

	typedef struct packed {
		logic [D_W-1:0] rem;
		logic [D_W-1:0] den;
		logic [Q_W-1:0] bits;
	} tpjp_div_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] angle;
		logic [PH_W-1:0]         phase;
		logic                    done;
	} tpjp_res_t;

endpackage

// File: src/tpjp_front.sv
// Front end of the profile pipeline: phase decode, squares and products, the
// fraction numerator and the divider operands. Depends on tpjp_pkg.
module tpjp_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [tpjp_pkg::ANG_W-1:0]  start_angle,
	input  logic signed [tpjp_pkg::ANG_W-1:0]  end_angle,
	input  logic [tpjp_pkg::ET_W-1:0]          elapsed_time,
	input  logic [tpjp_pkg::PT_W-1:0]          phase_ticks,
	output logic                               div_valid,
	output tpjp_pkg::tpjp_side_t               div_side,
	output tpjp_pkg::tpjp_div_t                div_data
);
	import tpjp_pkg::*;

	logic valid_s1, valid_s2, valid_s3;

	// Stage 1: clamp time, pick phase and time within phase.
	logic [PT_W-1:0]   p_c;
	logic [PT_W:0]     p2_c;
	logic [PT_W+1:0]   p3_c;
	logic [PT_W+1:0]   es_c;
	logic [PT_W+1:0]   rw_c;
	logic              done_c;
	logic [PH_W-1:0]   phase_c;
	tpjp_side_t        side_s1;
	logic [PT_W-1:0]   r_s1;
	logic [PT_W-1:0]   p_s1;

	always_comb begin
		p_c    = (phase_ticks == '0) ? PT_W'(1) : phase_ticks;
		p2_c   = {p_c, 1'b0};
		p3_c   = (PT_W+2)'(p2_c) + (PT_W+2)'(p_c);
		done_c = ((PT_W+2)'(elapsed_time) >= p3_c);
		es_c   = done_c ? p3_c : (PT_W+2)'(elapsed_time);
		priority if (es_c <= (PT_W+2)'(p_c)) begin
			phase_c = PH_ACCEL;
			rw_c    = es_c;
		end else if (es_c <= (PT_W+2)'(p2_c)) begin
			phase_c = PH_STEADY;
			rw_c    = es_c - (PT_W+2)'(p_c);
		end else begin
			phase_c = PH_BRAKE;
			rw_c    = es_c - (PT_W+2)'(p2_c);
		end
	end

	// Stage 2: the three products.
	tpjp_side_t        side_s2;
	logic [2*PT_W-1:0] rr_s2, pp_s2, rp_s2;

	// Stage 3: numerator over the move length 4*P^2, exact modulo 2^D_W.
	logic [D_W-1:0]    rr_x, pp_x, rp2_x, n_c;
	tpjp_side_t        side_s3;
	logic [D_W-1:0]    n_s3, d_s3;

	always_comb begin
		rr_x  = D_W'(rr_s2);
		pp_x  = D_W'(pp_s2);
		rp2_x = D_W'(rp_s2) << 1;
		unique case (side_s2.phase)
			PH_ACCEL:  n_c = rr_x;
			PH_STEADY: n_c = pp_x + rp2_x;
			PH_BRAKE:  n_c = (pp_x << 1) + pp_x + rp2_x - rr_x;
			default:   n_c = rr_x;
		endcase
	end

	// Stage 4: scaled numerator with half the divisor added for rounding.
	logic [N_W-1:0] num_c;

	assign num_c = N_W'({n_s3, {FRAC_BITS{1'b0}}}) + N_W'(d_s3 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			div_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			div_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.start <= start_angle;
		side_s1.diff  <= (ANG_W+1)'(end_angle) - (ANG_W+1)'(start_angle);
		side_s1.phase <= phase_c;
		side_s1.done  <= done_c;
		r_s1          <= rw_c[PT_W-1:0];
		p_s1          <= p_c;

		side_s2 <= side_s1;
		rr_s2   <= r_s1 * r_s1;
		pp_s2   <= p_s1 * p_s1;
		rp_s2   <= r_s1 * p_s1;

		side_s3 <= side_s2;
		n_s3    <= n_c;
		d_s3    <= pp_x << 2;

		div_side      <= side_s3;
		div_data.rem  <= num_c[N_W-1:Q_W];
		div_data.den  <= d_s3;
		div_data.bits <= num_c[Q_W-1:0];
	end

endmodule

// File: src/tpjp_div_step.sv
// One stage of the restoring divider: brings in one numerator bit and produces
// one quotient bit. Depends on tpjp_pkg.
module tpjp_div_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  tpjp_pkg::tpjp_side_t in_side,
	input  tpjp_pkg::tpjp_div_t  in_div,
	output logic                 out_valid,
	output tpjp_pkg::tpjp_side_t out_side,
	output tpjp_pkg::tpjp_div_t  out_div
);
	import tpjp_pkg::*;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         ge;

	always_comb begin
		trial = {in_div.rem, in_div.bits[Q_W-1]};
		diff  = trial - {1'b0, in_div.den};
		ge    = (trial >= {1'b0, in_div.den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_side     <= in_side;
		out_div.den  <= in_div.den;
		out_div.rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		out_div.bits <= {in_div.bits[Q_W-2:0], ge};
	end

endmodule

// File: src/tpjp_back.sv
// Back end of the profile pipeline: scales the angle difference by the rounded
// fraction and adds the start angle. Depends on tpjp_pkg.
module tpjp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  tpjp_pkg::tpjp_side_t           in_side,
	input  logic [tpjp_pkg::Q_W-1:0]       in_frac,
	output logic                           out_valid,
	output tpjp_pkg::tpjp_res_t            out_res
);
	import tpjp_pkg::*;

	logic signed [ANG_W:0]    diff_x;
	logic signed [Q_W:0]      frac_x;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] sum_c;
	logic signed [PROD_W-1:0] shf_c;
	logic signed [ANG_W-1:0]  start_s1;
	logic [PH_W-1:0]          phase_s1;
	logic                     done_s1;

	assign diff_x = in_side.diff;
	assign frac_x = {1'b0, in_frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= diff_x * frac_x;
		start_s1 <= in_side.start;
		phase_s1 <= in_side.phase;
		done_s1  <= in_side.done;
	end

	// Round half up, then floor by an arithmetic shift.
	always_comb begin
		sum_c         = prod_s1 + (PROD_W'(1) <<< (FRAC_BITS - 1));
		shf_c         = sum_c >>> FRAC_BITS;
		out_res.angle = start_s1 + shf_c[ANG_W-1:0];
		out_res.phase = phase_s1;
		out_res.done  = done_s1;
	end

endmodule

// File: src/tpjp_out_fifo.sv
// Result queue at the output of the profile pipeline, written every cycle that
// the pipeline delivers and drained through a registered head by the output channel.
// Depends on tpjp_pkg.
module tpjp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  tpjp_pkg::tpjp_res_t wr_res,
	output logic                rd_valid,
	input  logic                rd_ready,
	output tpjp_pkg::tpjp_res_t rd_res
);
	import tpjp_pkg::*;

	tpjp_res_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW:0]   wr_ptr_q;
	logic [FIFO_AW:0]   rd_ptr_q;
	tpjp_res_t          head_q;
	logic               head_valid_q;
	logic               mem_empty;
	logic               head_load;

	// The head register refills from the array whenever it is empty or being drained.
	assign mem_empty = (wr_ptr_q == rd_ptr_q);
	assign head_load = !mem_empty && (!head_valid_q || rd_ready);
	assign rd_valid  = head_valid_q;
	assign rd_res    = head_q;

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem_q[wr_ptr_q[FIFO_AW-1:0]] <= wr_res;
		end
		if (head_load) begin
			head_q <= mem_q[rd_ptr_q[FIFO_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (head_load) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			head_valid_q <= head_load || (head_valid_q && !rd_ready);
		end
	end

	// The credit scheme upstream must never let the queue overflow.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> (wr_ptr_q[FIFO_AW-1:0] != rd_ptr_q[FIFO_AW-1:0])
		|| mem_empty || head_load)
		else $error("result queue written while full");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(FIFO_AW+1)'(wr_ptr_q - rd_ptr_q) <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue fill level beyond its depth");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && !rd_ready) |=> (rd_valid && $stable(rd_res)))
		else $error("waiting result changed before its transfer");

endmodule

// File: src/three_phase_joint_profile_unit.sv
// Top level of the three-phase joint profile unit: configuration register,
// credit counter and the front end, divider, back end and result queue.
// Depends on tpjp_pkg and the tpjp_* modules.
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// joint's start angle, target angle and elapsed time, and gives exactly one
// transfer on the output channel (out_valid/out_ready) with the interpolated
// angle, the move phase and the done flag, in input order.
// The phase length is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while no item is in flight, not enforced by the block. It
// takes effect at the next input transfer. Between an input transfer and
// out_valid an item passes four front-end stages, one stage per quotient bit
// of the 17-bit divider, one multiplier stage, the result queue write and
// the queue's output register. Throughput is one item per cycle with credit.
// The pipeline itself never stalls. A credit counter admits an item only
// while the 32-entry result queue has room for every item in flight, so when
// the receiver stalls the input keeps being accepted until that headroom is
// used up, and nothing is lost or repeated.
// Reset empties the pipeline and the queue and sets the phase length to 2000
// ticks; there is no clearing pass.
module three_phase_joint_profile_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tpjp_pkg::PT_W-1:0]          cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tpjp_pkg::ANG_W-1:0]  start_angle,
	input  logic signed [tpjp_pkg::ANG_W-1:0]  end_angle,
	input  logic [tpjp_pkg::ET_W-1:0]          elapsed_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tpjp_pkg::ANG_W-1:0]  angle_out,
	output logic [tpjp_pkg::PH_W-1:0]          move_phase,
	output logic                               move_done
);
	import tpjp_pkg::*;

	logic [PT_W-1:0]  phase_ticks_q;
	logic [CNT_W-1:0] credit_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	// Items accepted but not yet delivered must all fit in the result queue.
	assign in_ready = (credit_q != CNT_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PT_RESET;
		end else if (cfg_wr_en) begin
			phase_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// The divider chain: one register stage per quotient bit.
	logic       dv_valid [Q_W+1];
	tpjp_side_t dv_side  [Q_W+1];
	tpjp_div_t  dv_data  [Q_W+1];

	tpjp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_xfer),
		.start_angle  (start_angle),
		.end_angle    (end_angle),
		.elapsed_time (elapsed_time),
		.phase_ticks  (phase_ticks_q),
		.div_valid    (dv_valid[0]),
		.div_side     (dv_side[0]),
		.div_data     (dv_data[0])
	);

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		tpjp_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[i]),
			.in_side   (dv_side[i]),
			.in_div    (dv_data[i]),
			.out_valid (dv_valid[i+1]),
			.out_side  (dv_side[i+1]),
			.out_div   (dv_data[i+1])
		);
	end

	logic      res_valid;
	tpjp_res_t res;
	tpjp_res_t head;

	tpjp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid[Q_W]),
		.in_side   (dv_side[Q_W]),
		.in_frac   (dv_data[Q_W].bits),
		.out_valid (res_valid),
		.out_res   (res)
	);

	tpjp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_res   (res),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_res   (head)
	);

	assign angle_out  = head.angle;
	assign move_phase = head.phase;
	assign move_done  = head.done;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CNT_W'(FIFO_DEPTH))
		else $error("credit count beyond result queue depth");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (credit_q != '0))
		else $error("result offered with no item in flight");

	a_done_is_braking: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && move_done) |-> (move_phase == PH_BRAKE))
		else $error("finished move reported outside the braking phase");

	a_queue_write_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (credit_q != '0))
		else $error("pipeline delivered a result with no item in flight");

endmodule

// File: dv/three_phase_joint_profile_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_phase_joint_profile_unit: directed and random moves
// checked against an in-bench profile predictor. Depends on tpjp_pkg and the unit's RTL only.
module three_phase_joint_profile_unit_test;
	import tpjp_pkg::*;

	// The slowest correct run is about 600 moves plus a drain of the pipeline around
	// every phase-length write; the limit is far above that.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// Extra wait at the end, longer than the unit's path from an input transfer to its result.
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned REPORT_LIMIT = 40;

	localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};
	localparam logic signed [ANG_W-1:0] ANG_MAX = ~ANG_MIN;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [PT_W-1:0]         cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [ANG_W-1:0] start_angle;
	logic signed [ANG_W-1:0] end_angle;
	logic [ET_W-1:0]         elapsed_time;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [ANG_W-1:0] angle_out;
	logic [PH_W-1:0]         move_phase;
	logic                    move_done;

	// The bench's own copy of the phase length, updated whenever the register is written.
	logic [PT_W-1:0] model_phase_ticks;
	// Expected results, oldest first, one for every accepted move.
	tpjp_res_t       pending_points[$];

	int unsigned points_sent     = 0;
	int unsigned points_checked  = 0;
	int unsigned length_settings = 0;
	int unsigned mismatches      = 0;
	int unsigned cycles          = 0;
	bit          sender_idles;
	bit          receiver_idles;

	three_phase_joint_profile_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_angle  (start_angle),
		.end_angle    (end_angle),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.angle_out    (angle_out),
		.move_phase   (move_phase),
		.move_done    (move_done)
	);

	always #5 clk = ~clk;

	// Predicts one point of the move. The covered fraction is kept as an exact numerator
	// over 4*P^2, rounded once to Q1.16, and then applied to the 33-bit difference with
	// round half up. An arithmetic shift of a signed value is a floor, which is what the
	// rounding needs for negative differences.
	function automatic tpjp_res_t profile_point(logic signed [ANG_W-1:0] from_ang,
			logic signed [ANG_W-1:0] to_ang, logic [ET_W-1:0] ticks,
			logic [PT_W-1:0] length);
		tpjp_res_t         pt;
		longint unsigned   p, span, den, t, r, num, frac;
		longint            delta, prod;
		// A zero phase length behaves as a length of one tick.
		p    = (length == '0) ? 64'd1 : 64'(length);
		span = 3 * p;
		den  = 4 * p * p;
		// Time past the end of the move is held at the end, where the angle is the target.
		pt.done = (64'(ticks) >= span);
		t       = (64'(ticks) > span) ? span : 64'(ticks);
		// A time exactly on a phase boundary still belongs to the earlier phase.
		if (t <= p) begin
			pt.phase = PH_ACCEL;
			r        = t;
			num      = r * r;
		end else if (t <= 2 * p) begin
			pt.phase = PH_STEADY;
			r        = t - p;
			num      = p * (p + 2 * r);
		end else begin
			pt.phase = PH_BRAKE;
			r        = t - 2 * p;
			num      = 3 * p * p + 2 * r * p - r * r;
		end
		frac     = ((num << FRAC_BITS) + den / 2) / den;
		delta    = longint'(from_ang);
		delta    = longint'(to_ang) - delta;
		prod     = delta * longint'(frac) + (longint'(1) << (FRAC_BITS - 1));
		pt.angle = ANG_W'(longint'(from_ang) + (prod >>> FRAC_BITS));
		return pt;
	endfunction

	// Offers one move on the input channel after a random gap and returns at the edge
	// where it is transferred. A move that follows with no gap keeps valid high and only
	// changes the payload, so valid never gets two assignments in one time step.
	task automatic send_point(logic signed [ANG_W-1:0] from_ang,
			logic signed [ANG_W-1:0] to_ang, logic [ET_W-1:0] ticks);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		start_angle  <= from_ang;
		end_angle    <= to_ang;
		elapsed_time <= ticks;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_points.push_back(profile_point(from_ang, to_ang, ticks, model_phase_ticks));
		points_sent++;
	endtask

	// Writes the phase length once every move in flight has delivered its result. Each
	// move gives exactly one result, so an empty expectation queue means the unit is idle.
	task automatic write_phase_length(logic [PT_W-1:0] length);
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= length;
		@(posedge clk);
		cfg_wr_en         <= 1'b0;
		model_phase_ticks = length;
		length_settings++;
	endtask

	// One random move. Most times fall inside the move so that every phase is visited at
	// any phase length; some land right on a boundary and some anywhere in 16 bits.
	task automatic send_random_point();
		logic signed [ANG_W-1:0] a, b;
		logic [ET_W-1:0]         t;
		int unsigned             p, span, bnd;
		p    = (model_phase_ticks == '0) ? 1 : model_phase_ticks;
		span = 3 * p;
		case ($urandom_range(0, 9))
			0, 1: t = ET_W'($urandom_range(0, 65535));
			2: begin
				bnd = p * $urandom_range(1, 3);
				if ($urandom_range(0, 1) != 0)
					bnd = bnd + 1;
				t = (bnd > 65535) ? '1 : ET_W'(bnd);
			end
			default: t = (span + 2 > 65535) ? ET_W'($urandom_range(0, 65535))
				: ET_W'($urandom_range(0, span + 2));
		endcase
		a = $urandom;
		case ($urandom_range(0, 7))
			// Short moves make the rounding of small differences visible.
			0: b = a + ANG_W'($urandom_range(0, 4000)) - ANG_W'(2000);
			1: begin
				a = ($urandom_range(0, 1) != 0) ? ANG_MAX : ANG_MIN;
				b = ($urandom_range(0, 1) != 0) ? ~a : ANG_W'($urandom);
			end
			2: b = a;
			default: b = $urandom;
		endcase
		send_point(a, b, t);
	endtask

	// Reset length of 2000 ticks: every phase boundary, saturation, and the rounding of
	// an exact half in both directions.
	task automatic test_default_length();
		send_point('0, 32'sd100 <<< 16, 16'd0);
		send_point(ANG_MIN, ANG_MAX, 16'd2000);
		send_point(ANG_MAX, ANG_MIN, 16'd2001);
		send_point(ANG_MIN, ANG_MAX, 16'd4000);
		send_point(ANG_MAX, ANG_MIN, 16'd4001);
		send_point(-(32'sd5 <<< 16), 32'sd7 <<< 16, 16'd5999);
		send_point(-(32'sd5 <<< 16), 32'sd7 <<< 16, 16'd6000);
		send_point(32'sd12345, -32'sd54321, 16'd6001);
		send_point(ANG_MIN, ANG_MAX, 16'hFFFF);
		// Half-way through the move the fraction is exactly one half.
		send_point('0, 32'sd1, 16'd3000);
		send_point('0, -32'sd1, 16'd3000);
		send_point(ANG_MAX, ANG_MAX, 16'd1234);
	endtask

	// Phase lengths at and beyond the ends of the range.
	task automatic test_length_extremes();
		write_phase_length('0);
		send_point(ANG_MIN, ANG_MAX, 16'd0);
		send_point(ANG_MIN, ANG_MAX, 16'd1);
		send_point(ANG_MAX, ANG_MIN, 16'd2);
		send_point(ANG_MIN, ANG_MAX, 16'd3);
		write_phase_length(PT_W'(1));
		send_point(ANG_MAX, ANG_MIN, 16'd2);
		send_point(ANG_MIN, ANG_MAX, 16'hFFFF);
		// Three phases of 21845 ticks end exactly at the largest elapsed time.
		write_phase_length(PT_W'(21845));
		send_point(ANG_MAX, ANG_MIN, 16'hFFFF);
		send_point(ANG_MAX, ANG_MIN, 16'hFFFE);
		send_point(ANG_MIN, ANG_MAX, 16'd21845);
		// Above the range the move outlasts the elapsed time and is never done.
		write_phase_length('1);
		send_point(ANG_MIN, ANG_MAX, 16'hFFFF);
		send_point(ANG_MAX, ANG_MIN, 16'd32767);
		send_point(ANG_MIN, ANG_MAX, 16'd32768);
	endtask

	// Random moves under a spread of phase lengths, with idling switched per setting.
	task automatic test_random_lengths();
		logic [PT_W-1:0] lengths [8];
		lengths[0] = PT_W'(2);
		lengths[1] = PT_W'(5);
		lengths[2] = PT_W'($urandom_range(1, 64));
		lengths[3] = PT_W'($urandom_range(65, 3000));
		lengths[4] = PT_RESET;
		lengths[5] = PT_W'(21845);
		lengths[6] = PT_W'($urandom);
		lengths[7] = '0;
		foreach (lengths[i]) begin
			write_phase_length(lengths[i]);
			sender_idles   = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			repeat (55) send_random_point();
		end
	endtask

	// Back-to-back transfers on both sides for a while.
	task automatic test_full_rate();
		write_phase_length(PT_W'($urandom_range(1, 100)));
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		repeat (80) send_random_point();
	endtask

	// An eager sender against a stalling receiver, so the credit limit is reached.
	task automatic test_result_backpressure();
		write_phase_length(PT_W'(3));
		sender_idles   = 1'b0;
		receiver_idles = 1'b1;
		repeat (60) send_random_point();
	endtask

	initial begin : stimulus
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		in_valid     <= 1'b0;
		start_angle  <= '0;
		end_angle    <= '0;
		elapsed_time <= '0;
		model_phase_ticks = PT_RESET;
		sender_idles      = 1'b1;
		receiver_idles    = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_length();
		test_length_extremes();
		test_random_lengths();
		test_full_rate();
		test_result_backpressure();

		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d moves under %0d phase-length writes; %0d results compared, %0d mismatches.",
			points_sent, length_settings, points_checked, mismatches);
		$display("Covered every phase and boundary, saturation, zero and over-range lengths, stalls.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: before each result the receiver may hold ready low for a random number
	// of cycles, then keeps it high until a transfer takes place.
	initial begin : result_receiver
		int unsigned hold;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = receiver_idles ? $urandom_range(0, 9) : 0;
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic report_field(string field, longint want, longint got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Every result transfer is compared with the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		tpjp_res_t want;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result, expected none, got angle %0d phase %0d done %0d",
						$time, angle_out, move_phase, move_done);
			end else begin
				want = pending_points.pop_front();
				points_checked++;
				if (angle_out !== want.angle)
					report_field("angle_out", want.angle, angle_out);
				if (move_phase !== want.phase)
					report_field("move_phase", want.phase, move_phase);
				if (move_done !== want.done)
					report_field("move_done", want.done, move_done);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles, %0d results outstanding",
				$time, CYCLE_LIMIT, pending_points.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// File: sim.f
src/tpjp_pkg.sv
src/tpjp_front.sv
src/tpjp_div_step.sv
src/tpjp_back.sv
src/tpjp_out_fifo.sv
src/three_phase_joint_profile_unit.sv
dv/three_phase_joint_profile_unit_test.sv
